>>> rtl/wsdm_pkg.sv
// Shared constants, register indexes and exponential tables for the waveshaper.
`timescale 1ns / 1ps

package wsdm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_SHAPE_MODE = 2'd0;
    localparam logic [1:0] REG_CLIP_THR   = 2'd1;
    localparam logic [1:0] REG_WET_MIX    = 2'd2;

    // Shaping mode codes.
    localparam logic [1:0] MODE_BYPASS    = 2'd0;
    localparam logic [1:0] MODE_HARD_CLIP = 2'd1;
    localparam logic [1:0] MODE_SOFT_CLIP = 2'd2;
    localparam logic [1:0] MODE_RECTIFY   = 2'd3;

    localparam int CFG_ADDR_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 23;
    localparam int THR_WIDTH      = 23;
    localparam int MIX_WIDTH      = 17;
    localparam int EXP_IDX_WIDTH  = 5;
    localparam int EXP_TAB_WIDTH  = 18;
    localparam int EXP_DIFF_WIDTH = 15;

    localparam logic [THR_WIDTH-1:0] THR_RESET = 23'h7FFFFF;
    localparam logic [MIX_WIDTH-1:0] MIX_ONE   = 17'h10000;

    // exp(k/8) for k = -8..8 in unsigned Q.16, rounded to nearest.
    function automatic logic [EXP_TAB_WIDTH-1:0] exp_base(input logic [EXP_IDX_WIDTH-1:0] idx);
        logic [EXP_TAB_WIDTH-1:0] v;
        case (idx)
            5'd0:    v = 18'd24109;
            5'd1:    v = 18'd27319;
            5'd2:    v = 18'd30957;
            5'd3:    v = 18'd35079;
            5'd4:    v = 18'd39750;
            5'd5:    v = 18'd45042;
            5'd6:    v = 18'd51039;
            5'd7:    v = 18'd57835;
            5'd8:    v = 18'd65536;
            5'd9:    v = 18'd74262;
            5'd10:   v = 18'd84150;
            5'd11:   v = 18'd95354;
            5'd12:   v = 18'd108051;
            5'd13:   v = 18'd122437;
            5'd14:   v = 18'd138740;
            5'd15:   v = 18'd157213;
            5'd16:   v = 18'd178145;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Difference to the next entry; the top entry has no neighbor and slopes zero.
    function automatic logic [EXP_DIFF_WIDTH-1:0] exp_slope(input logic [EXP_IDX_WIDTH-1:0] idx);
        logic [EXP_DIFF_WIDTH-1:0] v;
        case (idx)
            5'd0:    v = 15'd3210;
            5'd1:    v = 15'd3638;
            5'd2:    v = 15'd4122;
            5'd3:    v = 15'd4671;
            5'd4:    v = 15'd5292;
            5'd5:    v = 15'd5997;
            5'd6:    v = 15'd6796;
            5'd7:    v = 15'd7701;
            5'd8:    v = 15'd8726;
            5'd9:    v = 15'd9888;
            5'd10:   v = 15'd11204;
            5'd11:   v = 15'd12697;
            5'd12:   v = 15'd14386;
            5'd13:   v = 15'd16303;
            5'd14:   v = 15'd18473;
            5'd15:   v = 15'd20932;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/waveshaper_distortion_mix_top.sv
// Throughput: one sample per cycle; each of the six stages holds one beat and
// moves on whenever the stage after it is empty or moving.
// Reset: empties the pipeline and sets shape_mode to bypass, clip_threshold to
// full scale and wet_mix to fully shaped.
// Modes: bypass, hard clip, exponential soft clip (interpolated table), pass above thr.
`timescale 1ns / 1ps

module waveshaper_distortion_mix_top #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [wsdm_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [wsdm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    // Input stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample_in, zero pad above
    // Output stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata   // sample_out, zero pad above
);

    import wsdm_pkg::*;

    localparam int W   = SAMPLE_WIDTH;
    localparam int DW  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int F   = SAMPLE_WIDTH - 1;
    localparam int FRW = F - 3;
    localparam int CW  = ((SAMPLE_WIDTH > 24) ? SAMPLE_WIDTH : 24) + 1;
    localparam int YW  = CW + 1;
    localparam int PW  = EXP_DIFF_WIDTH + FRW;
    localparam int AW  = F + EXP_TAB_WIDTH;
    localparam int EW  = F + 2;
    localparam int SW  = YW + 19;
    localparam int RW  = SW - 16;

    localparam logic signed [CW-1:0] ONE_C = CW'(1) << F;
    localparam logic signed [YW-1:0] ONE_Y = YW'(1) << F;
    localparam logic signed [RW-1:0] R_MAX = (RW'(1) << F) - RW'(1);
    localparam logic signed [RW-1:0] R_MIN = -R_MAX - RW'(1);
    localparam logic signed [SW-1:0] HALF  = SW'(32768);

    // Configuration registers.
    logic [1:0]           mode_reg;
    logic [THR_WIDTH-1:0] thr_reg;
    logic [MIX_WIDTH-1:0] mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BYPASS;
            thr_reg  <= THR_RESET;
            mix_reg  <= MIX_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SHAPE_MODE: mode_reg <= cfg_data[1:0];
                REG_CLIP_THR:   thr_reg  <= cfg_data[THR_WIDTH-1:0];
                REG_WET_MIX:    mix_reg  <= cfg_data[MIX_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    // Stage valids and the backward enable chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !v6_reg || m_axis_tready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // Stage 1: threshold compare and exponential table index.
    logic signed [W-1:0]      x_in;
    logic signed [CW-1:0]     x_c;
    logic signed [CW-1:0]     thr_c;
    logic signed [CW-1:0]     t_c;
    logic [CW-1:0]            u_c;
    logic                     gt_next, lt_next;
    logic [EXP_IDX_WIDTH-1:0] idx_next;
    logic [FRW-1:0]           frac_next;

    always_comb
    begin
        x_in      = $signed(s_axis_tdata[W-1:0]);
        x_c       = CW'(x_in);
        thr_c     = $signed({{(CW-THR_WIDTH){1'b0}}, thr_reg});
        gt_next   = x_c > thr_c;
        lt_next   = x_c < -thr_c;
        // Above the threshold the curve mirrors, so the exponent is taken of -x.
        t_c       = gt_next ? -x_c : x_c;
        u_c       = $unsigned(t_c + ONE_C);
        idx_next  = u_c[W:F-3];
        frac_next = u_c[FRW-1:0];
    end

    logic signed [W-1:0]      s1_x_reg;
    logic                     s1_gt_reg, s1_lt_reg;
    logic [EXP_IDX_WIDTH-1:0] s1_idx_reg;
    logic [FRW-1:0]           s1_frac_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_x_reg    <= x_in;
            s1_gt_reg   <= gt_next;
            s1_lt_reg   <= lt_next;
            s1_idx_reg  <= idx_next;
            s1_frac_reg <= frac_next;
        end
    end

    // Stage 2: table lookup and slope times fraction.
    logic [EXP_TAB_WIDTH-1:0] base_next;
    logic [PW-1:0]            prod_next;

    always_comb
    begin
        base_next = exp_base(s1_idx_reg);
        prod_next = PW'(exp_slope(s1_idx_reg)) * PW'(s1_frac_reg);
    end

    logic signed [W-1:0]      s2_x_reg;
    logic                     s2_gt_reg, s2_lt_reg;
    logic [EXP_TAB_WIDTH-1:0] s2_base_reg;
    logic [PW-1:0]            s2_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_x_reg    <= s1_x_reg;
            s2_gt_reg   <= s1_gt_reg;
            s2_lt_reg   <= s1_lt_reg;
            s2_base_reg <= base_next;
            s2_prod_reg <= prod_next;
        end
    end

    // Stage 3: interpolated exponential, rounded half up to the sample scale.
    logic [AW-1:0] acc_c;
    logic [EW-1:0] e_next;

    always_comb
    begin
        acc_c  = {s2_base_reg, {F{1'b0}}} + (AW'(s2_prod_reg) << 3) + AW'(32768);
        e_next = acc_c[16 +: EW];
    end

    logic signed [W-1:0] s3_x_reg;
    logic                s3_gt_reg, s3_lt_reg;
    logic [EW-1:0]       s3_e_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_x_reg  <= s2_x_reg;
            s3_gt_reg <= s2_gt_reg;
            s3_lt_reg <= s2_lt_reg;
            s3_e_reg  <= e_next;
        end
    end

    // Stage 4: shaped value per mode, and the wet/dry weights.
    logic signed [YW-1:0] x_y, thr_y, e_y, y_next;
    logic [MIX_WIDTH-1:0] wet_next, dry_next;

    always_comb
    begin
        x_y   = YW'(s3_x_reg);
        thr_y = $signed({{(YW-THR_WIDTH){1'b0}}, thr_reg});
        e_y   = $signed({{(YW-EW){1'b0}}, s3_e_reg});
        case (mode_reg)
            MODE_HARD_CLIP: y_next = s3_gt_reg ? thr_y : (s3_lt_reg ? -thr_y : x_y);
            MODE_SOFT_CLIP: y_next = s3_gt_reg ? (ONE_Y - e_y) : (e_y - ONE_Y);
            MODE_RECTIFY:   y_next = s3_gt_reg ? x_y : '0;
            default:        y_next = x_y;
        endcase
        wet_next = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
        dry_next = MIX_ONE - wet_next;
    end

    logic signed [W-1:0]  s4_x_reg;
    logic signed [YW-1:0] s4_y_reg;
    logic [MIX_WIDTH-1:0] s4_wet_reg, s4_dry_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_x_reg   <= s3_x_reg;
            s4_y_reg   <= y_next;
            s4_wet_reg <= wet_next;
            s4_dry_reg <= dry_next;
        end
    end

    // Stage 5: weighted products.
    logic signed [YW+17:0] pw_next;
    logic signed [W+17:0]  pd_next;

    always_comb
    begin
        pw_next = (YW+18)'(s4_y_reg) * (YW+18)'($signed({1'b0, s4_wet_reg}));
        pd_next = (W+18)'(s4_x_reg) * (W+18)'($signed({1'b0, s4_dry_reg}));
    end

    logic signed [YW+17:0] s5_pw_reg;
    logic signed [W+17:0]  s5_pd_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_pw_reg <= pw_next;
            s5_pd_reg <= pd_next;
        end
    end

    // Stage 6: sum, round half up, saturate into the output register.
    logic signed [SW-1:0] sum_c;
    logic signed [RW-1:0] r_c;
    logic signed [W-1:0]  out_next;

    always_comb
    begin
        sum_c = SW'(s5_pw_reg) + SW'(s5_pd_reg) + HALF;
        r_c   = sum_c[SW-1:16];
        if (r_c > R_MAX)
            out_next = W'(R_MAX);
        else if (r_c < R_MIN)
            out_next = W'(R_MIN);
        else
            out_next = r_c[W-1:0];
    end

    logic signed [W-1:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = v6_reg;
    assign m_axis_tdata  = DW'($unsigned(out_reg));

    // An empty output stage means nothing upstream can be stalled.
    assert property (@(posedge clk) disable iff (!rst_n) !v6_reg |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    // The table index never goes past the top entry, and the top entry has no fraction.
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (s1_idx_reg <= 5'd16) && ((s1_idx_reg != 5'd16) || (s1_frac_reg == '0)))
        else $error("exponential table index out of range");

    // A held beat in a middle stage stays valid.
    assert property (@(posedge clk) disable iff (!rst_n) (v3_reg && !en3) |=> v3_reg)
        else $error("stalled beat dropped from stage 3");

    // The two weights always add up to unity.
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> ((MIX_WIDTH+1)'(s4_wet_reg) + (MIX_WIDTH+1)'(s4_dry_reg)
                    == (MIX_WIDTH+1)'(MIX_ONE)))
        else $error("wet and dry weights do not sum to one");

endmodule
